FILE: rtl/core/sbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared widths, register indexes and pipeline word types of the segment
// box clipper.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Coordinate, difference and parameter formats.
  localparam int CW    = 32;
  localparam int DW    = CW + 1;
  localparam int PF    = 16;
  localparam int QB    = PF + 2;
  localparam int TW    = QB + 1;
  localparam int NW    = DW + PF;
  localparam int RW    = DW + QB;
  localparam int PW    = TW + DW;
  localparam int QIW   = $clog2(QB);
  localparam int NLANE = 4;

  localparam logic signed [TW-1:0] T_ONE = TW'(1 << PF);

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // One side's division in flight.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] den;
    logic [QB-1:0] quo;
    logic          pneg;
    logic          qneg;
    logic          pzero;
    logic          sat;
  } lane_t;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic                 vld;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    lane_t [NLANE-1:0]    lane;
  } div_word_t;

  // Running clip interval.
  typedef struct packed {
    logic                 ok;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
  } tpair_t;

endpackage
`default_nettype wire

FILE: rtl/core/sbc_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_div_cell
// One restoring division step for all four sides, registered toward the
// next cell together with the rest of the word.
// ----------------------------------------------------------------------------
module sbc_div_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic [sbc_pkg::QIW-1:0] bit_idx,
  input  wire sbc_pkg::div_word_t     w_in,
  output sbc_pkg::div_word_t          w_out
);

  sbc_pkg::div_word_t w_nxt;
  sbc_pkg::div_word_t w_r;

  // Trial subtract of the shifted divisor; the quotient bit shifts in low.
  always_comb begin
    logic [sbc_pkg::RW-1:0] sh;
    logic                   ge;
    w_nxt = w_in;
    for (int l = 0; l < sbc_pkg::NLANE; l++) begin
      sh = sbc_pkg::RW'(w_in.lane[l].den) << bit_idx;
      ge = (w_in.lane[l].rem >= sh);
      if (ge) begin
        w_nxt.lane[l].rem = w_in.lane[l].rem - sh;
      end
      w_nxt.lane[l].quo = {w_in.lane[l].quo[sbc_pkg::QB-2:0], ge};
    end
  end

  // Pipeline register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else if (adv) begin
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r;

endmodule
`default_nettype wire

FILE: rtl/core/sbc_side_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_side_cell
// Narrows the clip interval against one side of the box.
// ----------------------------------------------------------------------------
module sbc_side_cell (
  input  wire sbc_pkg::lane_t  lane,
  input  wire sbc_pkg::tpair_t t_in,
  output sbc_pkg::tpair_t      t_out
);

  logic [sbc_pkg::QB-1:0]        mag;
  logic signed [sbc_pkg::TW-1:0] r;

  // Signed quotient; a saturated magnitude still orders correctly.
  assign mag = lane.sat ? {sbc_pkg::QB{1'b1}} : lane.quo;
  assign r   = (lane.pneg ^ lane.qneg) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Entry sides raise t0, exit sides lower t1; a parallel side only keeps or rejects.
  always_comb begin
    t_out = t_in;
    if (t_in.ok) begin
      if (lane.pzero) begin
        t_out.ok = !lane.qneg;
      end else if (!lane.pneg) begin
        if (r < t_in.t0) begin
          t_out.ok = 1'b0;
        end else if (r < t_in.t1) begin
          t_out.t1 = r;
        end
      end else begin
        if (r > t_in.t1) begin
          t_out.ok = 1'b0;
        end else if (r > t_in.t0) begin
          t_out.t0 = r;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sbc_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_interp
// Scales a parameter product back to coordinates and adds the start point.
// ----------------------------------------------------------------------------
module sbc_interp (
  input  wire logic signed [sbc_pkg::PW-1:0] prod,
  input  wire logic        [sbc_pkg::CW-1:0] base,
  output logic             [sbc_pkg::CW-1:0] pt
);

  logic signed [sbc_pkg::PW-1:0] bias;
  logic signed [sbc_pkg::PW-1:0] sum;
  logic signed [sbc_pkg::PW-1:0] shf;

  // Shift right with truncation toward zero.
  assign bias = prod[sbc_pkg::PW-1] ? sbc_pkg::PW'((1 << sbc_pkg::PF) - 1) : '0;
  assign sum  = prod + bias;
  assign shf  = sum >>> sbc_pkg::PF;
  assign pt   = base + shf[sbc_pkg::CW-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/segment_box_clipper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_box_clipper
// Clips line segments against an axis-aligned box held in registers.
// ----------------------------------------------------------------------------
// Usage: the box edges are written through cfg_we/cfg_idx/cfg_data while the
// block is idle. Each input word carries a segment (start and end point,
// signed Q16.16); each gives exactly one output word with the accept flag,
// the clipped endpoints and the moved flags. A rejected segment returns all
// zeros.
// Throughput is one segment per clock while the receiver does not stall. The
// pipeline has one setup stage, a row of 18 divider cells (one quotient bit
// per cell for all four sides at once), one interval stage, one multiply
// stage and the output register.
// Reset clears the box to the point (0,0) and empties the pipeline.
// While a valid output word is stalled, the whole pipeline holds and in_stall
// rises in the same cycle; the output word stays stable until it is taken.
// ----------------------------------------------------------------------------
module segment_box_clipper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_start_x,
  input  wire logic [31:0] in_start_y,
  input  wire logic [31:0] in_end_x,
  input  wire logic [31:0] in_end_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accepted,
  output logic [31:0]      out_clip_start_x,
  output logic [31:0]      out_clip_start_y,
  output logic [31:0]      out_clip_end_x,
  output logic [31:0]      out_clip_end_y,
  output logic             out_start_moved,
  output logic             out_end_moved
);

  localparam int CW = sbc_pkg::CW;
  localparam int DW = sbc_pkg::DW;
  localparam int QB = sbc_pkg::QB;
  localparam int TW = sbc_pkg::TW;
  localparam int PW = sbc_pkg::PW;
  localparam int RW = sbc_pkg::RW;
  localparam int PF = sbc_pkg::PF;

  logic adv;

  // Box registers.
  logic signed [CW-1:0] left_r, right_r, top_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sbc_pkg::REG_LEFT:   left_r   <= cfg_data;
        sbc_pkg::REG_RIGHT:  right_r  <= cfg_data;
        sbc_pkg::REG_TOP:    top_r    <= cfg_data;
        sbc_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Setup: direction and distance terms for each side.
  sbc_pkg::div_word_t chain [QB+1];
  sbc_pkg::div_word_t setup_nxt;

  always_comb begin
    logic signed [DW-1:0] ax, ay, dx, dy;
    logic signed [DW-1:0] p [sbc_pkg::NLANE];
    logic signed [DW-1:0] q [sbc_pkg::NLANE];
    logic [DW-1:0]        pm, qm;
    logic [RW-1:0]        num;
    ax = DW'($signed(in_start_x));
    ay = DW'($signed(in_start_y));
    dx = DW'($signed(in_end_x)) - ax;
    dy = DW'($signed(in_end_y)) - ay;
    p[0] = -dx;  q[0] = ax - DW'(left_r);
    p[1] = dx;   q[1] = DW'(right_r) - ax;
    p[2] = -dy;  q[2] = ay - DW'(top_r);
    p[3] = dy;   q[3] = DW'(bottom_r) - ay;
    setup_nxt.vld = in_valid;
    setup_nxt.ax  = in_start_x;
    setup_nxt.ay  = in_start_y;
    setup_nxt.dx  = dx;
    setup_nxt.dy  = dy;
    for (int l = 0; l < sbc_pkg::NLANE; l++) begin
      pm  = p[l][DW-1] ? DW'(-p[l]) : DW'(p[l]);
      qm  = q[l][DW-1] ? DW'(-q[l]) : DW'(q[l]);
      num = RW'({qm, {PF{1'b0}}});
      setup_nxt.lane[l].rem   = num;
      setup_nxt.lane[l].den   = pm;
      setup_nxt.lane[l].quo   = '0;
      setup_nxt.lane[l].pneg  = p[l][DW-1];
      setup_nxt.lane[l].qneg  = q[l][DW-1];
      setup_nxt.lane[l].pzero = (p[l] == '0);
      setup_nxt.lane[l].sat   = (num >= (RW'(pm) << QB));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0] <= setup_nxt;
    end
  end

  // Row of divider cells, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_div
    sbc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .bit_idx (sbc_pkg::QIW'(QB - 1 - k)),
      .w_in    (chain[k]),
      .w_out   (chain[k+1])
    );
  end

  // Interval stage: the four sides in order.
  sbc_pkg::tpair_t tp [sbc_pkg::NLANE+1];

  assign tp[0].ok = 1'b1;
  assign tp[0].t0 = '0;
  assign tp[0].t1 = sbc_pkg::T_ONE;

  for (genvar s = 0; s < sbc_pkg::NLANE; s++) begin : g_side
    sbc_side_cell u_side (
      .lane  (chain[QB].lane[s]),
      .t_in  (tp[s]),
      .t_out (tp[s+1])
    );
  end

  logic                 s_vld_r;
  sbc_pkg::tpair_t      s_t_r;
  logic signed [CW-1:0] s_ax_r, s_ay_r;
  logic signed [DW-1:0] s_dx_r, s_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= chain[QB].vld;
      s_t_r   <= tp[sbc_pkg::NLANE];
      s_ax_r  <= chain[QB].ax;
      s_ay_r  <= chain[QB].ay;
      s_dx_r  <= chain[QB].dx;
      s_dy_r  <= chain[QB].dy;
    end
  end

  // Multiply stage: parameter times direction.
  logic                 m_vld_r, m_ok_r, m_mv0_r, m_mv1_r;
  logic [CW-1:0]        m_ax_r, m_ay_r, m_bx_r, m_by_r;
  logic signed [PW-1:0] m_psx_r, m_psy_r, m_pex_r, m_pey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= s_vld_r;
      m_ok_r  <= s_t_r.ok;
      m_mv0_r <= (s_t_r.t0 > $signed(TW'(0)));
      m_mv1_r <= (s_t_r.t1 < sbc_pkg::T_ONE);
      m_ax_r  <= s_ax_r;
      m_ay_r  <= s_ay_r;
      m_bx_r  <= s_ax_r + s_dx_r[CW-1:0];
      m_by_r  <= s_ay_r + s_dy_r[CW-1:0];
      m_psx_r <= s_t_r.t0 * s_dx_r;
      m_psy_r <= s_t_r.t0 * s_dy_r;
      m_pex_r <= s_t_r.t1 * s_dx_r;
      m_pey_r <= s_t_r.t1 * s_dy_r;
    end
  end

  // Final stage: new endpoints and output register.
  logic [CW-1:0] sx, sy, ex, ey;

  sbc_interp u_isx (.prod(m_psx_r), .base(m_ax_r), .pt(sx));
  sbc_interp u_isy (.prod(m_psy_r), .base(m_ay_r), .pt(sy));
  sbc_interp u_iex (.prod(m_pex_r), .base(m_ax_r), .pt(ex));
  sbc_interp u_iey (.prod(m_pey_r), .base(m_ay_r), .pt(ey));

  logic          out_valid_r, acc_r, mv0_r, mv1_r;
  logic [CW-1:0] csx_r, csy_r, cex_r, cey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_vld_r;
      acc_r       <= m_ok_r;
      mv0_r       <= m_ok_r && m_mv0_r;
      mv1_r       <= m_ok_r && m_mv1_r;
      csx_r       <= !m_ok_r ? '0 : (m_mv0_r ? sx : m_ax_r);
      csy_r       <= !m_ok_r ? '0 : (m_mv0_r ? sy : m_ay_r);
      cex_r       <= !m_ok_r ? '0 : (m_mv1_r ? ex : m_bx_r);
      cey_r       <= !m_ok_r ? '0 : (m_mv1_r ? ey : m_by_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_clip_start_x = csx_r;
  assign out_clip_start_y = csy_r;
  assign out_clip_end_x   = cex_r;
  assign out_clip_end_y   = cey_r;
  assign out_start_moved  = mv0_r;
  assign out_end_moved    = mv1_r;

endmodule
`default_nettype wire

FILE: tb/sv/segment_box_clipper_tb.sv
// ----------------------------------------------------------------------------
// segment_box_clipper_tb
// Self-checking bench for the Liang-Barsky segment clipper. A queue of
// segments feeds a clocked driver, and a clocked monitor checks each output
// word against a built-in clipping predictor. The run steps through several
// box settings, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module segment_box_clipper_tb;

  localparam int LIMIT   = 3000;
  localparam int DRAIN   = 40;
  localparam int HOLD    = 300;
  localparam longint ONE = 64'sd1 << sbc_pkg::PF;

  typedef struct {
    logic [31:0] sx, sy, ex, ey;
  } seg_t;

  typedef struct {
    logic        acc;
    logic [31:0] csx, csy, cex, cey;
    logic        smv, emv;
  } clip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = sbc_pkg::REG_LEFT;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted, out_start_moved, out_end_moved;
  logic [31:0] out_clip_start_x, out_clip_start_y, out_clip_end_x, out_clip_end_y;

  // Box copy used by the predictor.
  longint box_l, box_r, box_t, box_b;

  seg_t   seg_pending[$];
  seg_t   cur_seg;
  clip_t  clip_expected[$];
  int     errors = 0;
  int     n_in = 0, n_out = 0, n_hit = 0;
  int     idle_cycles = 0;
  bit     idle_on = 1'b1;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     src_gap = 0, snk_gap = 0;

  segment_box_clipper DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_clip_start_x(out_clip_start_x), .out_clip_start_y(out_clip_start_y),
    .out_clip_end_x(out_clip_end_x), .out_clip_end_y(out_clip_end_y),
    .out_start_moved(out_start_moved), .out_end_moved(out_end_moved)
  );

  always #5 clk = ~clk;

  // One side: the segment must satisfy p*t <= q.
  function automatic bit narrow(longint p, longint q, ref longint t0, ref longint t1);
    longint r;
    if (p == 0) return q >= 0;
    r = (q * ONE) / p;
    if (p > 0) begin
      if (r < t0) return 1'b0;
      if (r < t1) t1 = r;
    end else begin
      if (r > t1) return 1'b0;
      if (r > t0) t0 = r;
    end
    return 1'b1;
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    clip_t  c;
    longint ax, ay, dx, dy, t0, t1, px, py, qx, qy;
    bit     ok;
    ax = longint'($signed(s.sx));
    ay = longint'($signed(s.sy));
    dx = longint'($signed(s.ex)) - ax;
    dy = longint'($signed(s.ey)) - ay;
    t0 = 0;
    t1 = ONE;
    ok = narrow(-dx, ax - box_l, t0, t1) && narrow(dx, box_r - ax, t0, t1) &&
         narrow(-dy, ay - box_t, t0, t1) && narrow(dy, box_b - ay, t0, t1);
    c = '{1'b0, '0, '0, '0, '0, 1'b0, 1'b0};
    if (!ok) return c;
    px = ax; py = ay;
    qx = ax + dx; qy = ay + dy;
    if (t0 > 0) begin
      px = ax + (t0 * dx) / ONE;
      py = ay + (t0 * dy) / ONE;
    end
    if (t1 < ONE) begin
      qx = ax + (t1 * dx) / ONE;
      qy = ay + (t1 * dy) / ONE;
    end
    c.acc = 1'b1;
    c.csx = px[31:0]; c.csy = py[31:0];
    c.cex = qx[31:0]; c.cey = qy[31:0];
    c.smv = t0 > 0;
    c.emv = t1 < ONE;
    return c;
  endfunction

  // Driver: presents queued segments, with random gaps between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        clip_expected = {clip_expected, clip_segment(cur_seg)};
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (seg_pending.size() > 0) begin
          cur_seg = seg_pending.pop_front();
          in_start_x <= cur_seg.sx;
          in_start_y <= cur_seg.sy;
          in_end_x <= cur_seg.ex;
          in_end_y <= cur_seg.ey;
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall bursts, one long hold on request, and the word check.
  always @(posedge clk) begin
    clip_t c;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (clip_expected.size() == 0) begin
        $display("%0t: output word with nothing expected", $time);
        errors++;
      end else begin
        c = clip_expected.pop_front();
        if (out_accepted) n_hit++;
        if (out_accepted !== c.acc)
          $display("%0t: accepted exp %0b got %0b", $time, c.acc, out_accepted);
        if (out_clip_start_x !== c.csx)
          $display("%0t: clip_start_x exp %h got %h", $time, c.csx, out_clip_start_x);
        if (out_clip_start_y !== c.csy)
          $display("%0t: clip_start_y exp %h got %h", $time, c.csy, out_clip_start_y);
        if (out_clip_end_x !== c.cex)
          $display("%0t: clip_end_x exp %h got %h", $time, c.cex, out_clip_end_x);
        if (out_clip_end_y !== c.cey)
          $display("%0t: clip_end_y exp %h got %h", $time, c.cey, out_clip_end_y);
        if (out_start_moved !== c.smv)
          $display("%0t: start_moved exp %0b got %0b", $time, c.smv, out_start_moved);
        if (out_end_moved !== c.emv)
          $display("%0t: end_moved exp %0b got %0b", $time, c.emv, out_end_moved);
        if (out_accepted !== c.acc || out_clip_start_x !== c.csx ||
            out_clip_start_y !== c.csy || out_clip_end_x !== c.cex ||
            out_clip_end_y !== c.cey || out_start_moved !== c.smv ||
            out_end_moved !== c.emv)
          errors++;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      snk_gap = HOLD;
    end
    if (snk_gap > 0) begin
      snk_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("timeout with %0d words outstanding", clip_expected.size());
      $display("segment_box_clipper_tb NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    while (seg_pending.size() > 0 || in_valid || clip_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_box(longint l, longint r, longint t, longint b);
    logic [1:0] idx [4];
    longint     val [4];
    idx = '{sbc_pkg::REG_LEFT, sbc_pkg::REG_RIGHT, sbc_pkg::REG_TOP, sbc_pkg::REG_BOTTOM};
    val = '{l, r, t, b};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= val[i][31:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    box_l = l; box_r = r; box_t = t; box_b = b;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Coordinate around [lo, hi], mostly near the box, sometimes anywhere.
  function automatic logic [31:0] near(longint lo, longint hi);
    longint span, a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 64'sd65536;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return (lo < hi) ? lo[31:0] : hi[31:0];
      2: return hi[31:0];
      default:
        return clamp32(a - span / 2 + longint'($urandom()) % (2 * span));
    endcase
  endfunction

  task automatic add_seg(longint sx, longint sy, longint ex, longint ey);
    seg_t s;
    s = '{sx[31:0], sy[31:0], ex[31:0], ey[31:0]};
    seg_pending = {seg_pending, s};
  endtask

  task automatic add_random(int n);
    seg_t s;
    for (int i = 0; i < n; i++) begin
      s.sx = near(box_l, box_r);
      s.sy = near(box_t, box_b);
      s.ex = near(box_l, box_r);
      s.ey = near(box_t, box_b);
      // Some axis-parallel and zero-length segments.
      case ($urandom_range(0, 9))
        0: s.ex = s.sx;
        1: s.ey = s.sy;
        2: begin s.ex = s.sx; s.ey = s.sy; end
        default: ;
      endcase
      seg_pending = {seg_pending, s};
    end
  endtask

  localparam longint U = 64'sd65536;
  localparam longint MX = 64'sd2147483647;
  localparam longint MN = -64'sd2147483648;

  initial begin
    box_l = 0; box_r = 0; box_t = 0; box_b = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Point box right after reset.
    add_seg(0, 0, 0, 0);
    add_seg(-U, 0, U, 0);
    add_seg(U, U, 2 * U, 2 * U);
    add_seg(-U, -U, U, U);
    wait_idle();

    // Ordinary box: crossings, parallel inside and outside, zero length.
    write_box(-10 * U, 10 * U, -10 * U, 10 * U);
    add_seg(-20 * U, 0, 20 * U, 0);
    add_seg(20 * U, 5 * U, -20 * U, -5 * U);
    add_seg(0, -20 * U, 0, 20 * U);
    add_seg(-20 * U, 15 * U, 20 * U, 15 * U);
    add_seg(15 * U, -20 * U, 15 * U, 20 * U);
    add_seg(-5 * U, -5 * U, 5 * U, 5 * U);
    add_seg(3 * U, 3 * U, 3 * U, 3 * U);
    add_seg(30 * U, 3 * U, 30 * U, 3 * U);
    add_seg(10 * U, 10 * U, 10 * U, 10 * U);
    add_seg(-20 * U, 0, 0, 20 * U);
    add_seg(MN, MN, MX, MX);
    add_seg(MX, MN, MN, MX);
    add_seg(MX, MX, MX, MX);
    add_seg(MN, 0, MX, 0);
    wait_idle();

    // Random with a long output hold while the sender keeps offering.
    add_random(150);
    hold_req++;
    wait_idle();

    // Full-range box.
    write_box(MN, MX, MN, MX);
    add_seg(MN, MN, MX, MX);
    add_seg(MX, 0, MN, 0);
    add_random(150);
    wait_idle();

    // Inverted box: the inverted x range lets no segment pass.
    write_box(5 * U, -5 * U, -8 * U, 8 * U);
    add_seg(0, 0, 0, 4 * U);
    add_seg(-9 * U, 0, 9 * U, 0);
    add_random(100);
    wait_idle();

    // Random boxes with random segments.
    for (int k = 0; k < 3; k++) begin
      longint a, b;
      a = longint'($signed($urandom()));
      b = a + longint'($urandom_range(0, 32'h00FF_FFFF));
      write_box(a, (b > MX) ? MX : b, -longint'($urandom_range(1, 1 << 24)),
                longint'($urandom_range(1, 1 << 24)));
      add_random(100);
      wait_idle();
    end

    // Last part without idling on either side.
    write_box(-100 * U, 50 * U, -30 * U, 70 * U);
    idle_on = 1'b0;
    add_random(120);
    wait_idle();

    $display("clipped %0d segments (%0d inside) over point, ordinary, full-range,",
             n_out, n_hit);
    $display("inverted and random boxes with stalls on both channels");
    if (errors == 0 && clip_expected.size() == 0)
      $display("segment_box_clipper_tb OK");
    else
      $display("segment_box_clipper_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_div_cell.sv
rtl/core/sbc_side_cell.sv
rtl/core/sbc_interp.sv
rtl/core/segment_box_clipper.sv
tb/sv/segment_box_clipper_tb.sv
